### rtl/core/assert_macros.svh
// Assertion helpers used by the RTL of the string decoder core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every rising clock edge while reset is released.
`define ESD_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Checked at every rising clock edge, also while reset is held.
`define ESD_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

### rtl/core/esd_pkg.sv
package esd_pkg;

  // Escape parser modes, one-hot.
  typedef enum logic [6:0] {
    MODE_NORMAL = 7'b0000001,
    MODE_ESC    = 7'b0000010,
    MODE_HEX    = 7'b0000100,
    MODE_OCT    = 7'b0001000,
    MODE_USTART = 7'b0010000,
    MODE_U4     = 7'b0100000,
    MODE_UBRACE = 7'b1000000
  } mode_e;

  typedef enum logic [2:0] {
    ST_OK           = 3'd0,
    ST_BAD_LETTER   = 3'd1,
    ST_BAD_OCTAL    = 3'd2,
    ST_BAD_HEX      = 3'd3,
    ST_BAD_UNICODE  = 3'd4,
    ST_BAD_CODE_PT  = 3'd5,
    ST_NUM_ABOVE_3  = 3'd6,
    ST_UNTERMINATED = 3'd7
  } status_e;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       end_of_string;
    status_e    status;
  } res_t;

  localparam int unsigned MaxResults = 4;

  localparam logic [31:0] BraceLimit  = 32'h0FFF_FFFF;
  localparam logic [31:0] CodePointMax = 32'h0010_FFFF;
  localparam logic [31:0] SurrogateLo  = 32'h0000_D800;
  localparam logic [31:0] SurrogateHi  = 32'h0000_DFFF;

  localparam logic [7:0] ChBackslash = 8'h5C;
  localparam logic [7:0] ChOpenBrace = 8'h7B;
  localparam logic [7:0] ChCloseBrace = 8'h7D;
  localparam logic [7:0] ChZero      = 8'h30;
  localparam logic [7:0] ChThree     = 8'h33;
  localparam logic [7:0] ChSeven     = 8'h37;
  localparam logic [7:0] ChNine      = 8'h39;

  // Returns {is_hex_digit, digit_value}.
  function automatic logic [4:0] hex_digit(input logic [7:0] b);
    logic [4:0] r;
    r = 5'd0;
    if (b >= 8'h30 && b <= 8'h39) begin
      r = {1'b1, b[3:0]};
    end else if ((b >= 8'h61 && b <= 8'h66) || (b >= 8'h41 && b <= 8'h46)) begin
      r = {1'b1, b[3:0] + 4'd9};
    end
    return r;
  endfunction

endpackage

### rtl/core/esd_in_if.sv
interface esd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       is_final;

  modport source (output valid, output in_byte, output is_final, input ready);
  modport sink   (input valid, input in_byte, input is_final, output ready);
endinterface

### rtl/core/esd_out_if.sv
interface esd_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       byte_valid;
  logic       end_of_string;
  logic [2:0] status;
  logic       run_last;

  modport source (output valid, output out_byte, output byte_valid, output end_of_string,
                  output status, output run_last, input ready);
  modport sink   (input valid, input out_byte, input byte_valid, input end_of_string,
                  input status, input run_last, output ready);
endinterface

### rtl/core/escaped_string_decoder_core.sv
// Channel | Direction | Payload                                        | Handshake
// in_i    | sink      | in_byte[7:0], is_final                         | valid/ready
// out_o   | source    | out_byte[7:0], byte_valid, end_of_string,      | valid/ready
//         |           | status[2:0], run_last                          |
//
// Each input item is decoded in the cycle it is accepted; its results, up to four, are
// loaded into a result group register and leave one per cycle while the output is ready,
// from the next cycle on. With the output always ready, only an item with two or more
// results closes the input, and the next item enters as the last result leaves.
// Reset returns the parser to normal text mode and empties the result group.
// A stalled output keeps its result and the input stays closed until the group drains.
`include "assert_macros.svh"

module escaped_string_decoder_core
  import esd_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  esd_in_if.sink     in_i,
  esd_out_if.source  out_o
);

  // Parser state.
  mode_e       mode_q, mode_d;
  logic [31:0] acc_q, acc_d;
  logic [3:0]  cnt_q, cnt_d;
  logic        fault_q, fault_d;

  // Result group: the results of one item, read out by index.
  res_t        grp_q [MaxResults];
  res_t        res_d [MaxResults];
  logic [2:0]  grp_n_q;
  logic [2:0]  res_n;
  logic [1:0]  idx_q;

  logic in_accept, out_take, last_take;

  // Actions requested by the escape parser; resolved after the mode case.
  logic        do_emit, do_fail, do_cp;
  logic [7:0]  emit_val;
  status_e     fail_st;
  logic [31:0] cp_val;
  logic [4:0]  hx;
  logic        lone_zero;
  logic        alpha;

  assign hx    = hex_digit(in_i.in_byte);
  assign alpha = (in_i.in_byte >= 8'h61 && in_i.in_byte <= 8'h7A) ||
                 (in_i.in_byte >= 8'h41 && in_i.in_byte <= 8'h5A);
  assign lone_zero = !fault_q && (mode_q == MODE_OCT) && (cnt_q == 4'd0) && (acc_q == 32'd0);

  always_comb begin
    mode_d   = mode_q;
    acc_d    = acc_q;
    cnt_d    = cnt_q;
    fault_d  = fault_q;
    do_emit  = 1'b0;
    do_fail  = 1'b0;
    do_cp    = 1'b0;
    emit_val = 8'd0;
    fail_st  = ST_OK;
    cp_val   = 32'd0;
    res_n    = 3'd0;
    for (int i = 0; i < MaxResults; i++) begin
      res_d[i] = '0;
    end

    if (in_i.is_final) begin
      // The closing quote always ends the literal; an open escape is reported
      // except for a lone \0, which still gives its zero byte first.
      if (lone_zero) begin
        res_d[0].byte_valid = 1'b1;
        res_n = 3'd1;
      end
      res_d[res_n[1:0]].end_of_string = 1'b1;
      res_d[res_n[1:0]].status = (!fault_q && mode_q != MODE_NORMAL && !lone_zero) ?
                                 ST_UNTERMINATED : ST_OK;
      res_n   = res_n + 3'd1;
      mode_d  = MODE_NORMAL;
      acc_d   = 32'd0;
      cnt_d   = 4'd0;
      fault_d = 1'b0;
    end else if (!fault_q) begin
      case (mode_q)
        MODE_ESC: begin
          if (alpha) begin
            case (in_i.in_byte)
              8'h61: begin do_emit = 1'b1; emit_val = 8'd7;  end
              8'h62: begin do_emit = 1'b1; emit_val = 8'd8;  end
              8'h74: begin do_emit = 1'b1; emit_val = 8'd9;  end
              8'h6E: begin do_emit = 1'b1; emit_val = 8'd10; end
              8'h76: begin do_emit = 1'b1; emit_val = 8'd11; end
              8'h66: begin do_emit = 1'b1; emit_val = 8'd12; end
              8'h72: begin do_emit = 1'b1; emit_val = 8'd13; end
              8'h78: begin
                mode_d = MODE_HEX;
                acc_d  = 32'd0;
                cnt_d  = 4'd0;
              end
              8'h75: begin
                mode_d = MODE_USTART;
                acc_d  = 32'd0;
                cnt_d  = 4'd0;
              end
              default: begin
                do_fail = 1'b1;
                fail_st = ST_BAD_LETTER;
              end
            endcase
          end else if (in_i.in_byte >= ChZero && in_i.in_byte <= ChNine) begin
            if (in_i.in_byte > ChThree) begin
              do_fail = 1'b1;
              fail_st = ST_NUM_ABOVE_3;
            end else begin
              mode_d = MODE_OCT;
              acc_d  = {30'd0, in_i.in_byte[1:0]};
              cnt_d  = 4'd0;
            end
          end else begin
            do_emit  = 1'b1;
            emit_val = in_i.in_byte;
          end
        end
        MODE_HEX: begin
          if (!hx[4]) begin
            do_fail = 1'b1;
            fail_st = ST_BAD_HEX;
          end else begin
            acc_d = {24'd0, acc_q[3:0], hx[3:0]};
            cnt_d = cnt_q + 4'd1;
            if (cnt_q + 4'd1 >= 4'd2) begin
              do_emit  = 1'b1;
              emit_val = acc_d[7:0];
            end
          end
        end
        MODE_OCT: begin
          if (in_i.in_byte < ChZero || in_i.in_byte > ChSeven) begin
            do_fail = 1'b1;
            fail_st = ST_BAD_OCTAL;
          end else begin
            acc_d = {24'd0, acc_q[4:0], in_i.in_byte[2:0]};
            cnt_d = cnt_q + 4'd1;
            if (cnt_q + 4'd1 >= 4'd2) begin
              do_emit  = 1'b1;
              emit_val = acc_d[7:0];
            end
          end
        end
        MODE_USTART: begin
          if (in_i.in_byte == ChOpenBrace) begin
            mode_d = MODE_UBRACE;
            acc_d  = 32'd0;
            cnt_d  = 4'd0;
          end else if (!hx[4]) begin
            do_fail = 1'b1;
            fail_st = ST_BAD_UNICODE;
          end else begin
            mode_d = MODE_U4;
            acc_d  = {28'd0, hx[3:0]};
            cnt_d  = 4'd1;
          end
        end
        MODE_U4: begin
          if (!hx[4]) begin
            do_fail = 1'b1;
            fail_st = ST_BAD_UNICODE;
          end else begin
            acc_d = {16'd0, acc_q[11:0], hx[3:0]};
            cnt_d = cnt_q + 4'd1;
            if (cnt_q + 4'd1 >= 4'd4) begin
              do_cp  = 1'b1;
              cp_val = acc_d;
            end
          end
        end
        MODE_UBRACE: begin
          if (in_i.in_byte == ChCloseBrace) begin
            do_cp  = 1'b1;
            cp_val = acc_q;
          end else if (!hx[4] || acc_q > BraceLimit) begin
            // A further digit once the value passes the limit would overflow.
            do_fail = 1'b1;
            fail_st = ST_BAD_UNICODE;
          end else begin
            acc_d = {acc_q[27:0], hx[3:0]};
          end
        end
        default: begin
          // Normal text, and the recovery path for an unused mode code.
          mode_d = MODE_NORMAL;
          acc_d  = 32'd0;
          cnt_d  = 4'd0;
          if (in_i.in_byte == ChBackslash) begin
            mode_d = MODE_ESC;
          end else begin
            do_emit  = 1'b1;
            emit_val = in_i.in_byte;
          end
        end
      endcase

      // A code point outside Unicode or in the surrogate range is an error.
      if (do_cp && (cp_val > CodePointMax ||
                    (cp_val >= SurrogateLo && cp_val <= SurrogateHi))) begin
        do_cp   = 1'b0;
        do_fail = 1'b1;
        fail_st = ST_BAD_CODE_PT;
      end

      if (do_fail) begin
        res_d[0].status = fail_st;
        res_n   = 3'd1;
        fault_d = 1'b1;
      end else if (do_emit) begin
        res_d[0].out_byte   = emit_val;
        res_d[0].byte_valid = 1'b1;
        res_n = 3'd1;
      end else if (do_cp) begin
        // UTF-8 encoding, one to four bytes.
        for (int i = 0; i < MaxResults; i++) begin
          res_d[i].byte_valid = 1'b1;
        end
        if (cp_val < 32'h80) begin
          res_d[0].out_byte = cp_val[7:0];
          res_n = 3'd1;
        end else if (cp_val < 32'h800) begin
          res_d[0].out_byte = {3'b110, cp_val[10:6]};
          res_d[1].out_byte = {2'b10, cp_val[5:0]};
          res_n = 3'd2;
        end else if (cp_val < 32'h10000) begin
          res_d[0].out_byte = {4'b1110, cp_val[15:12]};
          res_d[1].out_byte = {2'b10, cp_val[11:6]};
          res_d[2].out_byte = {2'b10, cp_val[5:0]};
          res_n = 3'd3;
        end else begin
          res_d[0].out_byte = {5'b11110, cp_val[20:18]};
          res_d[1].out_byte = {2'b10, cp_val[17:12]};
          res_d[2].out_byte = {2'b10, cp_val[11:6]};
          res_d[3].out_byte = {2'b10, cp_val[5:0]};
          res_n = 3'd4;
        end
      end

      if (do_fail || do_emit || do_cp) begin
        mode_d = MODE_NORMAL;
        acc_d  = 32'd0;
        cnt_d  = 4'd0;
      end
    end
  end

  // Handshake. The input is open while the group is empty or its last result leaves.
  assign out_take  = out_o.valid && out_o.ready;
  assign last_take = out_take && ({1'b0, idx_q} == grp_n_q - 3'd1);
  assign in_i.ready = (grp_n_q == 3'd0) || last_take;
  assign in_accept = in_i.valid && in_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= MODE_NORMAL;
      acc_q   <= 32'd0;
      cnt_q   <= 4'd0;
      fault_q <= 1'b0;
      grp_n_q <= 3'd0;
      idx_q   <= 2'd0;
    end else begin
      if (in_accept) begin
        mode_q  <= mode_d;
        acc_q   <= acc_d;
        cnt_q   <= cnt_d;
        fault_q <= fault_d;
      end
      // A new group replaces the one whose last result leaves in this cycle.
      if (in_accept && res_n != 3'd0) begin
        grp_n_q <= res_n;
        idx_q   <= 2'd0;
      end else if (last_take) begin
        grp_n_q <= 3'd0;
        idx_q   <= 2'd0;
      end else if (out_take) begin
        idx_q <= idx_q + 2'd1;
      end
    end
  end

  // Result payload needs no reset; the count qualifies it.
  always_ff @(posedge clk_i) begin
    if (in_accept && res_n != 3'd0) begin
      for (int i = 0; i < MaxResults; i++) begin
        grp_q[i] <= res_d[i];
      end
    end
  end

  assign out_o.valid         = (grp_n_q != 3'd0);
  assign out_o.out_byte      = grp_q[idx_q].out_byte;
  assign out_o.byte_valid    = grp_q[idx_q].byte_valid;
  assign out_o.end_of_string = grp_q[idx_q].end_of_string;
  assign out_o.status        = grp_q[idx_q].status;
  assign out_o.run_last      = ({1'b0, idx_q} == grp_n_q - 3'd1);

  `ESD_ASSERT(a_grp_count_range, grp_n_q <= 3'd4, "result group count above four")
  `ESD_ASSERT(a_idx_in_group,
              out_o.valid |-> ({1'b0, idx_q} < grp_n_q),
              "read index past group end")
  `ESD_ASSERT(a_fault_in_normal, fault_q |-> (mode_q == MODE_NORMAL), "fault with escape open")
  `ESD_ASSERT(a_final_clears,
              (in_accept && in_i.is_final) |=>
                (!fault_q && mode_q == MODE_NORMAL && acc_q == 32'd0),
              "final item did not clear state")
  `ESD_ASSERT_ALWAYS(a_no_accept_when_full,
                     (out_o.valid && !out_o.ready) |-> !in_i.ready,
                     "input open while group stalled")

endmodule
